// ----- rtl/core/nfc_rfp_pkg.sv -----
// ============================================================================
// nfc_rfp_pkg -- response frame parser shared definitions
// Phase codes, status codes, register indexes, reset values, frame constants and the result word.
// ============================================================================
package nfc_rfp_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_COMMAND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_IDENTIFIER = 2'd2;

    localparam logic [7:0] RST_EXPECTED_COMMAND = 8'd0;
    localparam logic [7:0] RST_MAX_PAYLOAD      = 8'd64;
    localparam logic [7:0] RST_FRAME_IDENTIFIER = 8'd213;

    // Frame constants
    localparam logic [7:0] START_BYTE     = 8'hFF;
    localparam logic [7:0] POSTAMBLE_BYTE = 8'h00;
    localparam logic [7:0] PREAMBLE_BYTE  = 8'h00;
    localparam logic [7:0] LEN_OVERHEAD   = 8'd2;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2
    } status_t;

    // Parser phase
    typedef enum logic [2:0] {
        PH_PREAMBLE = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_COMMAND  = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_TRAILER  = 3'd4
    } phase_t;

    // One result word
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        status_t    status;
        logic [7:0] payload_length;
        logic       last;
    } result_t;

endpackage

// ----- rtl/core/nfc_response_frame_parser_top.sv -----
// ============================================================================
// nfc_response_frame_parser_top -- response frame parser
// Checks a received information frame byte by byte, passes payload bytes
// on and reports one status word at the end of each frame.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | rx_byte
//  out     | output    | out_valid/out_stall| kind, data_byte, status,
//          |           |                    | payload_length, last
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One byte is accepted per cycle; the frame state updates at the accepting
// edge, and any result is loaded into the output register at that same edge
// and offered from the next cycle on.
// The output register drains while a new byte enters, so throughput is one
// byte per cycle unless the receiver stalls with a word still held.
// in_stall rises only while the output register is full and out_stall is high.
// Reset clears the frame state, the output valid and loads register defaults.
// ============================================================================
module nfc_response_frame_parser_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input byte channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                kind,
    output logic [7:0]                          data_byte,
    output logic [1:0]                          status,
    output logic [7:0]                          payload_length,
    output logic                                last,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [nfc_rfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nfc_rfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [7:0] expected_command_reg;
    logic [7:0] max_payload_reg;
    logic [7:0] frame_identifier_reg;

    // Frame state
    nfc_rfp_pkg::phase_t phase_reg, phase_next;
    logic [1:0] group_position_reg, group_position_next;
    logic       group_mismatch_reg, group_mismatch_next;
    logic [7:0] first_group_byte_reg, first_group_byte_next;
    logic [7:0] payload_count_reg, payload_count_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] payload_size_reg, payload_size_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    nfc_rfp_pkg::result_t result_reg, result_next;
    logic                 emit;

    logic       in_accept;
    logic [7:0] len_size;
    logic [7:0] sum_with_byte;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign len_size      = first_group_byte_reg - nfc_rfp_pkg::LEN_OVERHEAD;
    assign sum_with_byte = running_sum_reg + rx_byte;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_command_reg <= nfc_rfp_pkg::RST_EXPECTED_COMMAND;
            max_payload_reg      <= nfc_rfp_pkg::RST_MAX_PAYLOAD;
            frame_identifier_reg <= nfc_rfp_pkg::RST_FRAME_IDENTIFIER;
        end
        else if (cfg_we)
        begin
            if (cfg_index == nfc_rfp_pkg::REG_EXPECTED_COMMAND)
                expected_command_reg <= cfg_data;
            if (cfg_index == nfc_rfp_pkg::REG_MAX_PAYLOAD)
                max_payload_reg <= cfg_data;
            if (cfg_index == nfc_rfp_pkg::REG_FRAME_IDENTIFIER)
                frame_identifier_reg <= cfg_data;
        end
    end

    // Advance the frame state for one byte and build its result word
    always_comb
    begin
        logic                fin;
        nfc_rfp_pkg::status_t fin_status;
        logic [7:0]          fin_length;

        fin        = 1'b0;
        fin_status = nfc_rfp_pkg::ST_GOOD;
        fin_length = 8'd0;
        emit       = 1'b0;

        phase_next            = phase_reg;
        group_position_next   = group_position_reg;
        group_mismatch_next   = group_mismatch_reg;
        first_group_byte_next = first_group_byte_reg;
        payload_count_next    = payload_count_reg;
        running_sum_next      = running_sum_reg;
        payload_size_next     = payload_size_reg;

        result_next.kind           = nfc_rfp_pkg::KIND_DATA;
        result_next.data_byte      = 8'd0;
        result_next.status         = nfc_rfp_pkg::ST_GOOD;
        result_next.payload_length = 8'd0;
        result_next.last           = 1'b0;

        unique case (phase_reg)
            nfc_rfp_pkg::PH_LENGTH:
            begin
                if (group_position_reg == 2'd0)
                begin
                    first_group_byte_next = rx_byte;
                    group_position_next   = 2'd1;
                end
                else if ((first_group_byte_reg + rx_byte) != 8'd0)
                begin
                    fin        = 1'b1;
                    fin_status = nfc_rfp_pkg::ST_INVALID;
                end
                else if (len_size > max_payload_reg)
                begin
                    fin        = 1'b1;
                    fin_status = nfc_rfp_pkg::ST_NOSPACE;
                end
                else
                begin
                    payload_size_next     = len_size;
                    running_sum_next      = 8'd0;
                    phase_next            = nfc_rfp_pkg::PH_COMMAND;
                    group_position_next   = 2'd0;
                    group_mismatch_next   = 1'b0;
                    first_group_byte_next = 8'd0;
                end
            end

            nfc_rfp_pkg::PH_COMMAND:
            begin
                running_sum_next = sum_with_byte;
                if (group_position_reg == 2'd0)
                begin
                    if (rx_byte != frame_identifier_reg)
                        group_mismatch_next = 1'b1;
                    group_position_next = 2'd1;
                end
                else if (group_mismatch_reg || rx_byte != (expected_command_reg + 8'd1))
                begin
                    fin        = 1'b1;
                    fin_status = nfc_rfp_pkg::ST_INVALID;
                end
                else
                begin
                    payload_count_next    = 8'd0;
                    phase_next            = (payload_size_reg == 8'd0) ?
                                            nfc_rfp_pkg::PH_TRAILER :
                                            nfc_rfp_pkg::PH_PAYLOAD;
                    group_position_next   = 2'd0;
                    group_mismatch_next   = 1'b0;
                    first_group_byte_next = 8'd0;
                end
            end

            nfc_rfp_pkg::PH_PAYLOAD:
            begin
                running_sum_next   = sum_with_byte;
                payload_count_next = payload_count_reg + 8'd1;
                if (payload_count_next == payload_size_reg)
                begin
                    phase_next            = nfc_rfp_pkg::PH_TRAILER;
                    group_position_next   = 2'd0;
                    group_mismatch_next   = 1'b0;
                    first_group_byte_next = 8'd0;
                end
                emit                  = 1'b1;
                result_next.data_byte = rx_byte;
            end

            nfc_rfp_pkg::PH_TRAILER:
            begin
                if (group_position_reg == 2'd0)
                begin
                    if (sum_with_byte != 8'd0)
                        group_mismatch_next = 1'b1;
                    group_position_next = 2'd1;
                end
                else if (group_mismatch_reg || rx_byte != nfc_rfp_pkg::POSTAMBLE_BYTE)
                begin
                    fin        = 1'b1;
                    fin_status = nfc_rfp_pkg::ST_INVALID;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_status = nfc_rfp_pkg::ST_GOOD;
                    fin_length = payload_size_reg;
                end
            end

            nfc_rfp_pkg::PH_PREAMBLE:
            begin
                if (group_position_reg == 2'd2)
                begin
                    if (group_mismatch_reg || rx_byte != nfc_rfp_pkg::START_BYTE)
                    begin
                        fin        = 1'b1;
                        fin_status = nfc_rfp_pkg::ST_INVALID;
                    end
                    else
                    begin
                        phase_next            = nfc_rfp_pkg::PH_LENGTH;
                        group_position_next   = 2'd0;
                        group_mismatch_next   = 1'b0;
                        first_group_byte_next = 8'd0;
                    end
                end
                else
                begin
                    if (rx_byte != nfc_rfp_pkg::PREAMBLE_BYTE)
                        group_mismatch_next = 1'b1;
                    group_position_next = group_position_reg + 2'd1;
                end
            end

            default:
            begin
                phase_next          = nfc_rfp_pkg::PH_PREAMBLE;
                group_position_next = 2'd0;
                group_mismatch_next = 1'b0;
            end
        endcase

        // Close the frame: post the status word and drop back to preamble
        if (fin)
        begin
            emit                       = 1'b1;
            result_next.kind           = nfc_rfp_pkg::KIND_STATUS;
            result_next.data_byte      = 8'd0;
            result_next.status         = fin_status;
            result_next.payload_length = fin_length;
            result_next.last           = 1'b1;
            phase_next                 = nfc_rfp_pkg::PH_PREAMBLE;
            group_position_next        = 2'd0;
            group_mismatch_next        = 1'b0;
            first_group_byte_next      = 8'd0;
            payload_count_next         = 8'd0;
            running_sum_next           = 8'd0;
            payload_size_next          = 8'd0;
        end
    end

    // Output valid: load on a result, clear once taken, else hold
    always_comb
    begin
        if (in_accept && emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold frame state; advance only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= nfc_rfp_pkg::PH_PREAMBLE;
            group_position_reg   <= 2'd0;
            group_mismatch_reg   <= 1'b0;
            first_group_byte_reg <= 8'd0;
            payload_count_reg    <= 8'd0;
            running_sum_reg      <= 8'd0;
            payload_size_reg     <= 8'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                phase_reg            <= phase_next;
                group_position_reg   <= group_position_next;
                group_mismatch_reg   <= group_mismatch_next;
                first_group_byte_reg <= first_group_byte_next;
                payload_count_reg    <= payload_count_next;
                running_sum_reg      <= running_sum_next;
                payload_size_reg     <= payload_size_next;
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = result_reg.kind;
    assign data_byte      = result_reg.data_byte;
    assign status         = result_reg.status;
    assign payload_length = result_reg.payload_length;
    assign last           = result_reg.last;

endmodule
